[hw/rtl/ewh_pkg.sv]
// ewh_pkg: shared types and constants of the equi-width histogram estimator
// used by ewh_front, ewh_back and the top level, depends on nothing
`timescale 1ns / 1ps

package ewh_pkg;

  localparam int VAL_W     = 32;  // column value and configuration data width
  localparam int WID_W     = 33;  // bucket width, can reach 2^32
  localparam int IDX_W     = 7;   // bucket index and effective count
  localparam int CFG_IDX_W = 2;
  localparam int EST_W     = 32;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_EQ  = 3'd1,
    MODE_NE  = 3'd2,
    MODE_GT  = 3'd3,
    MODE_GE  = 3'd4,
    MODE_LT  = 3'd5,
    MODE_LE  = 3'd6
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW    = 2'd0,
    REG_RANGE_HIGH   = 2'd1,
    REG_BUCKET_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    JOB_ADD,
    JOB_ZERO,
    JOB_QUERY
  } job_e;

  typedef struct packed {
    job_e              kind;
    mode_e             mode;
    logic [IDX_W-1:0]  bkt;
    logic [IDX_W-1:0]  eff;
    logic [WID_W-1:0]  share_f;
    logic [WID_W-1:0]  wid;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PREP,
    F_GEOM,
    F_BKT,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_ADD_RD,
    B_ADD_WR,
    B_Q_RD,
    B_Q_LATCH,
    B_MUL,
    B_DIV_GO,
    B_DIV,
    B_SUM,
    B_DONE
  } back_state_e;

endpackage

[hw/rtl/ewh_ram.sv]
// ewh_ram: generic single write, single read RAM with registered read data
// no package dependencies
`timescale 1ns / 1ps

module ewh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/ewh_div.sv]
// ewh_div: restoring divider, one quotient bit per cycle
// no package dependencies
`timescale 1ns / 1ps

module ewh_div #(
  parameter int NW = 33,
  parameter int DW = 33
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(NW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[hw/rtl/ewh_fifo.sv]
// ewh_fifo: two-entry job queue between front and back
// no package dependencies
`timescale 1ns / 1ps

module ewh_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q;
  logic             rptr_q;
  logic [1:0]       cnt_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/ewh_front.sv]
// ewh_front: configuration registers, geometry, bucket lookup and job issue
// depends on ewh_pkg and ewh_div
`timescale 1ns / 1ps

module ewh_front #(
  parameter int NUM_BUCKETS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           hold_i,
  input  logic                           cfg_we_i,
  input  logic [ewh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ewh_pkg::VAL_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     mode_i,
  input  logic signed [ewh_pkg::VAL_W-1:0] value_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output ewh_pkg::job_t                  push_job_o
);

  localparam int W = ewh_pkg::WID_W;
  localparam int I = ewh_pkg::IDX_W;

  ewh_pkg::front_state_e state_q, state_d;

  logic signed [31:0] low_q, high_q;
  logic [I-1:0]       bc_q;
  logic               geo_ok_q;
  logic [W-1:0]       wid_q;
  ewh_pkg::mode_e     mode_q;
  logic signed [31:0] val_q;
  logic [I-1:0]       bkt_q;
  logic [I+W-1:0]     bw_q;
  ewh_pkg::job_e      kind_q, kind_d;

  logic signed [32:0] span;
  logic               empty;
  logic [W-1:0]       span_p1;
  logic [I-1:0]       eff;
  logic signed [31:0] vc;
  logic [32:0]        off_w;
  logic [31:0]        off;
  logic               in_range;
  logic               is_add;
  logic               mode_ok;
  logic [31:0]        lo;
  logic signed [34:0] fv;
  logic signed [34:0] wid_s;
  logic [W-1:0]       share_f;

  logic               div_start;
  logic [W-1:0]       div_num;
  logic [W-1:0]       div_den;
  logic               div_done;
  logic [W-1:0]       div_quo;

  ewh_div #(.NW(W), .DW(W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // geometry
  assign span    = {high_q[31], high_q} - {low_q[31], low_q};
  assign empty   = span[32] || (span == 33'sd0);
  assign span_p1 = W'(span) + W'(1);

  always_comb begin
    eff = (bc_q == '0) ? I'(1) : bc_q;
    if (32'(eff) > NUM_BUCKETS) begin
      eff = I'(NUM_BUCKETS);
    end
    if (!span[32] && ({26'b0, eff} > span)) begin
      eff = span[I-1:0];
    end
  end

  // item
  always_comb begin
    vc = val_q;
    if (val_q > high_q) begin
      vc = high_q;
    end
    if (val_q < low_q) begin
      vc = low_q;
    end
  end

  assign off_w    = {vc[31], vc} - {low_q[31], low_q};
  assign off      = off_w[31:0];
  assign in_range = (val_q >= low_q) && (val_q <= high_q);
  assign is_add   = (mode_q == ewh_pkg::MODE_ADD);
  assign mode_ok  = (mode_q != ewh_pkg::mode_e'(3'd7));

  // linear share factor within the bucket
  assign lo    = off - bw_q[31:0];
  assign wid_s = {2'b00, wid_q};

  always_comb begin
    case (mode_q)
      ewh_pkg::MODE_LT: fv = {3'b000, lo};
      ewh_pkg::MODE_LE: fv = {3'b000, lo} + 35'sd1;
      ewh_pkg::MODE_GE: fv = wid_s - {3'b000, lo};
      ewh_pkg::MODE_GT: fv = wid_s - {3'b000, lo} - 35'sd1;
      default:          fv = 35'sd1;
    endcase
    if (fv < 35'sd0) begin
      share_f = '0;
    end else if (fv > wid_s) begin
      share_f = wid_q;
    end else begin
      share_f = fv[W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    unique case (state_q)
      ewh_pkg::F_IDLE: begin
        if (in_valid_i && !hold_i) begin
          state_d = ewh_pkg::F_PREP;
        end
      end
      ewh_pkg::F_PREP: begin
        if (!mode_ok) begin
          state_d = ewh_pkg::F_IDLE;
        end else if (empty) begin
          kind_d  = ewh_pkg::JOB_ZERO;
          state_d = is_add ? ewh_pkg::F_IDLE : ewh_pkg::F_PUSH;
        end else if (is_add && !in_range) begin
          state_d = ewh_pkg::F_IDLE;
        end else begin
          kind_d  = is_add ? ewh_pkg::JOB_ADD : ewh_pkg::JOB_QUERY;
          state_d = geo_ok_q ? ewh_pkg::F_BKT : ewh_pkg::F_GEOM;
        end
      end
      ewh_pkg::F_GEOM: begin
        if (div_done) begin
          state_d = ewh_pkg::F_PREP;
        end
      end
      ewh_pkg::F_BKT: begin
        if (div_done) begin
          state_d = ewh_pkg::F_MUL;
        end
      end
      ewh_pkg::F_MUL: begin
        state_d = ewh_pkg::F_PUSH;
      end
      ewh_pkg::F_PUSH: begin
        if (push_ready_i) begin
          state_d = ewh_pkg::F_IDLE;
        end
      end
      default: state_d = ewh_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o   = (state_q != ewh_pkg::F_IDLE) || hold_i;
    push_valid_o = (state_q == ewh_pkg::F_PUSH);
    div_start    = (state_q == ewh_pkg::F_PREP) && mode_ok && !empty &&
                   (!is_add || in_range);
    div_num      = geo_ok_q ? {1'b0, off} : span_p1;
    div_den      = geo_ok_q ? wid_q : {26'b0, eff};
  end

  assign push_job_o.kind    = kind_q;
  assign push_job_o.mode    = mode_q;
  assign push_job_o.bkt     = bkt_q;
  assign push_job_o.eff     = eff;
  assign push_job_o.share_f = share_f;
  assign push_job_o.wid     = wid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ewh_pkg::F_IDLE;
      kind_q   <= ewh_pkg::JOB_ZERO;
      low_q    <= 32'sd0;
      high_q   <= 32'sd255;
      bc_q     <= I'(64);
      geo_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      if (cfg_we_i) begin
        geo_ok_q <= 1'b0;
        case (ewh_pkg::cfg_reg_e'(cfg_idx_i))
          ewh_pkg::REG_RANGE_LOW:    low_q  <= cfg_data_i;
          ewh_pkg::REG_RANGE_HIGH:   high_q <= cfg_data_i;
          ewh_pkg::REG_BUCKET_COUNT: bc_q   <= cfg_data_i[I-1:0];
          default: ;
        endcase
      end else if (state_q == ewh_pkg::F_GEOM && div_done) begin
        geo_ok_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ewh_pkg::F_IDLE && in_valid_i && !hold_i) begin
      mode_q <= ewh_pkg::mode_e'(mode_i);
      val_q  <= value_i;
    end
    if (state_q == ewh_pkg::F_GEOM && div_done) begin
      wid_q <= div_quo;
    end
    if (state_q == ewh_pkg::F_BKT && div_done) begin
      if (div_quo > W'(eff - I'(1))) begin
        bkt_q <= eff - I'(1);
      end else begin
        bkt_q <= div_quo[I-1:0];
      end
    end
    if (state_q == ewh_pkg::F_MUL) begin
      bw_q <= {{W{1'b0}}, bkt_q} * {{I{1'b0}}, wid_q};
    end
  end

endmodule

[hw/rtl/ewh_back.sv]
// ewh_back: bucket store, count updates, share arithmetic and bucket walk
// depends on ewh_pkg, ewh_ram and ewh_div
`timescale 1ns / 1ps

module ewh_back #(
  parameter int NUM_BUCKETS = 64,
  parameter int COUNT_BITS  = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  output logic                        clr_busy_o,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  ewh_pkg::job_t               pop_job_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ewh_pkg::EST_W-1:0]   estimate_o
);

  localparam int W     = ewh_pkg::WID_W;
  localparam int I     = ewh_pkg::IDX_W;
  localparam int CB    = COUNT_BITS;
  localparam int AW    = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
  localparam int PW    = CB + W;
  localparam int ACC_W = CB + I;
  localparam int FW    = (ACC_W + 1 > 33) ? ACC_W + 1 : 33;
  localparam int MCW   = $clog2(W + 1);

  ewh_pkg::back_state_e state_q, state_d;

  ewh_pkg::job_t     job_q;
  logic [AW-1:0]     clr_q;
  logic [CB-1:0]     total_q;
  logic [CB-1:0]     c_q;
  logic [PW-1:0]     prod_q;
  logic [W-1:0]      fsh_q;
  logic [MCW-1:0]    mcnt_q;
  logic [CB-1:0]     share_q;
  logic [ACC_W-1:0]  acc_q;
  logic [I-1:0]      idx_q;
  logic [I-1:0]      end_q;
  logic              pend_q;
  logic              out_valid_q;
  logic [ewh_pkg::EST_W-1:0] est_q;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CB-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CB-1:0]     ram_rdata;
  logic              div_done;
  logic [PW-1:0]     div_quo;
  logic              walk_on;
  logic              out_free;
  logic [FW-1:0]     est_full;
  logic [ewh_pkg::EST_W-1:0] est_sat;

  ewh_ram #(.WIDTH(CB), .DEPTH(NUM_BUCKETS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ewh_div #(.NW(PW), .DW(W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ewh_pkg::B_DIV_GO),
    .num_i   (prod_q),
    .den_i   (job_q.wid),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign walk_on  = idx_q < end_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    est_full = '0;
    if (job_q.kind != ewh_pkg::JOB_ZERO) begin
      case (job_q.mode)
        ewh_pkg::MODE_EQ: est_full = FW'(share_q);
        ewh_pkg::MODE_NE: est_full = (total_q > share_q) ? FW'(total_q - share_q) : '0;
        default:          est_full = FW'(acc_q) + FW'(share_q);
      endcase
    end
    if (est_full > FW'(33'h0_FFFF_FFFF)) begin
      est_sat = '1;
    end else begin
      est_sat = est_full[ewh_pkg::EST_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ewh_pkg::B_CLEAR: begin
        if (clr_q == AW'(NUM_BUCKETS - 1)) begin
          state_d = ewh_pkg::B_IDLE;
        end
      end
      ewh_pkg::B_IDLE: begin
        if (pop_valid_i) begin
          case (pop_job_i.kind)
            ewh_pkg::JOB_ADD:   state_d = ewh_pkg::B_ADD_RD;
            ewh_pkg::JOB_QUERY: state_d = ewh_pkg::B_Q_RD;
            default:            state_d = ewh_pkg::B_DONE;
          endcase
        end
      end
      ewh_pkg::B_ADD_RD:  state_d = ewh_pkg::B_ADD_WR;
      ewh_pkg::B_ADD_WR:  state_d = ewh_pkg::B_IDLE;
      ewh_pkg::B_Q_RD:    state_d = ewh_pkg::B_Q_LATCH;
      ewh_pkg::B_Q_LATCH: state_d = ewh_pkg::B_MUL;
      ewh_pkg::B_MUL: begin
        if (mcnt_q == MCW'(1)) begin
          state_d = ewh_pkg::B_DIV_GO;
        end
      end
      ewh_pkg::B_DIV_GO:  state_d = ewh_pkg::B_DIV;
      ewh_pkg::B_DIV: begin
        if (div_done) begin
          state_d = ewh_pkg::B_SUM;
        end
      end
      ewh_pkg::B_SUM: begin
        if (!walk_on && !pend_q) begin
          state_d = ewh_pkg::B_DONE;
        end
      end
      ewh_pkg::B_DONE: begin
        if (out_free) begin
          state_d = ewh_pkg::B_IDLE;
        end
      end
      default: state_d = ewh_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    clr_busy_o  = (state_q == ewh_pkg::B_CLEAR);
    pop_ready_o = (state_q == ewh_pkg::B_IDLE);
    ram_we      = 1'b0;
    ram_waddr   = AW'(job_q.bkt);
    ram_wdata   = (ram_rdata == {CB{1'b1}}) ? ram_rdata : ram_rdata + CB'(1);
    ram_raddr   = AW'(job_q.bkt);
    unique case (state_q)
      ewh_pkg::B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ewh_pkg::B_ADD_WR: ram_we = 1'b1;
      ewh_pkg::B_SUM:    ram_raddr = AW'(idx_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ewh_pkg::B_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ewh_pkg::B_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == ewh_pkg::B_ADD_WR && total_q != {CB{1'b1}}) begin
        total_q <= total_q + CB'(1);
      end
      if (state_q == ewh_pkg::B_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ewh_pkg::B_IDLE && pop_valid_i) begin
      job_q <= pop_job_i;
    end
    if (state_q == ewh_pkg::B_Q_LATCH) begin
      c_q    <= ram_rdata;
      prod_q <= '0;
      fsh_q  <= job_q.share_f;
      mcnt_q <= MCW'(W);
    end
    if (state_q == ewh_pkg::B_MUL) begin
      prod_q <= {prod_q[PW-2:0], 1'b0} + (fsh_q[W-1] ? PW'(c_q) : '0);
      fsh_q  <= {fsh_q[W-2:0], 1'b0};
      mcnt_q <= mcnt_q - MCW'(1);
    end
    if (state_q == ewh_pkg::B_DIV && div_done) begin
      share_q <= div_quo[CB-1:0];
      acc_q   <= '0;
      pend_q  <= 1'b0;
      case (job_q.mode)
        ewh_pkg::MODE_GT, ewh_pkg::MODE_GE: begin
          idx_q <= job_q.bkt + I'(1);
          end_q <= job_q.eff;
        end
        ewh_pkg::MODE_LT, ewh_pkg::MODE_LE: begin
          idx_q <= '0;
          end_q <= job_q.bkt;
        end
        default: begin
          idx_q <= '0;
          end_q <= '0;
        end
      endcase
    end
    if (state_q == ewh_pkg::B_SUM) begin
      if (walk_on) begin
        idx_q <= idx_q + I'(1);
      end
      pend_q <= walk_on;
      if (pend_q) begin
        acc_q <= acc_q + ACC_W'(ram_rdata);
      end
    end
    if (state_q == ewh_pkg::B_DONE && out_free) begin
      est_q <= est_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign estimate_o  = est_q;

endmodule

[hw/rtl/equi_width_histogram_estimator_unit.sv]
// equi_width_histogram_estimator_unit: top level of the histogram estimator
// depends on ewh_pkg, ewh_front, ewh_fifo and ewh_back
`timescale 1ns / 1ps

// Equi-width histogram row estimator. After reset the bucket store is cleared
// one entry a cycle, and in_stall_o stays high meanwhile. The front takes one
// beat at a time: a bucket lookup is a serial divide, plus a bucket width
// divide on the first beat after any register write. Mode 7, out of range
// adds and adds on an empty range leave from F_PREP and issue no job. Behind
// a two-entry queue the back does an add in B_ADD_RD and B_ADD_WR; a query
// runs a serial multiply and a serial divide of the linear share, then walks
// the buckets. The user must write registers only while the block is idle;
// the block itself does not enforce it.
module equi_width_histogram_estimator_unit #(
  parameter int NUM_BUCKETS = 64,
  parameter int COUNT_BITS  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ewh_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ewh_pkg::VAL_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [2:0]                           mode_i,
  input  logic signed [ewh_pkg::VAL_W-1:0]     value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ewh_pkg::EST_W-1:0]            estimate_o
);

  logic          clr_busy;
  logic          push_valid, push_ready;
  logic          pop_valid, pop_ready;
  ewh_pkg::job_t push_job, pop_job;

  ewh_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hold_i       (clr_busy),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  ewh_fifo #(.WIDTH($bits(ewh_pkg::job_t))) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  ewh_back #(.NUM_BUCKETS(NUM_BUCKETS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_busy_o  (clr_busy),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .estimate_o  (estimate_o)
  );

endmodule
